// ===== rtl/tpt_pkg.sv =====
// Shared constants and types for the TLB page-table translator.
`default_nettype none
package tpt_pkg;

  localparam int unsigned VA_W        = 16;
  localparam int unsigned OFFSET_W    = 8;
  localparam int unsigned PAGE_W      = 8;
  localparam int unsigned FRAME_W     = 8;
  localparam int unsigned PAGE_BYTES  = 256;
  localparam int unsigned PAGE_COUNT  = 256;
  localparam int unsigned FRAME_TOTAL = 256;
  localparam int unsigned NFF_W       = 9;
  localparam int unsigned TLB_ENTRIES = 16;

  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  tag;
    logic [FRAME_W-1:0] frame;
  } tlb_entry_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_match_t;

endpackage
`default_nettype wire

// ===== rtl/tpt_va_if.sv =====
// Request channel carrying one virtual address.
`default_nettype none
interface tpt_va_if;
  logic                       valid;
  logic                       ready;
  logic [tpt_pkg::VA_W-1:0]   virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpt_res_if.sv =====
// Result channel carrying one translation.
`default_nettype none
interface tpt_res_if;
  logic                        valid;
  logic                        ready;
  logic [tpt_pkg::VA_W-1:0]    physical_address;
  logic [tpt_pkg::FRAME_W-1:0] frame_number;
  logic [tpt_pkg::PAGE_W-1:0]  page_number;
  logic                        tlb_hit;
  logic                        page_fault;
  logic                        no_free_frame;

  modport source (output valid, output physical_address, output frame_number,
                  output page_number, output tlb_hit, output page_fault,
                  output no_free_frame, input ready);
  modport sink   (input valid, input physical_address, input frame_number,
                  input page_number, input tlb_hit, input page_fault,
                  input no_free_frame, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpt_tlb_cell.sv =====
// One TLB cell: holds an entry, shifts it on refill and extends the match chain.
`default_nettype none
module tpt_tlb_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          shift_i,
  input  wire tpt_pkg::tlb_entry_t           entry_i,
  input  wire logic [tpt_pkg::PAGE_W-1:0]    page_i,
  input  wire tpt_pkg::tlb_match_t           match_i,
  output tpt_pkg::tlb_entry_t                entry_o,
  output tpt_pkg::tlb_match_t                match_o
);

  logic                         valid_q;
  logic [tpt_pkg::PAGE_W-1:0]   tag_q;
  logic [tpt_pkg::FRAME_W-1:0]  frame_q;
  logic                         match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q   <= entry_i.tag;
      frame_q <= entry_i.frame;
    end
  end

  assign match = valid_q && (tag_q == page_i);

  assign entry_o.valid = valid_q;
  assign entry_o.tag   = tag_q;
  assign entry_o.frame = frame_q;

  assign match_o.hit   = match_i.hit | match;
  assign match_o.frame = match_i.hit ? match_i.frame :
                         (match ? frame_q : '0);

endmodule
`default_nettype wire

// ===== rtl/tpt_tlb.sv =====
// Row of TLB cells forming a shift FIFO with a lookup chain.
`default_nettype none
module tpt_tlb #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        refill_i,
  input  wire tpt_pkg::tlb_entry_t         new_entry_i,
  input  wire logic [tpt_pkg::PAGE_W-1:0]  page_i,
  output tpt_pkg::tlb_match_t              match_o
);

  tpt_pkg::tlb_entry_t entry_w [TLB_ENTRIES];
  tpt_pkg::tlb_match_t match_w [TLB_ENTRIES+1];

  assign match_w[0] = '0;

  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
    tpt_pkg::tlb_entry_t prev;
    if (k == 0) begin : g_head
      assign prev = new_entry_i;
    end else begin : g_body
      assign prev = entry_w[k-1];
    end

    tpt_tlb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (refill_i),
      .entry_i (prev),
      .page_i  (page_i),
      .match_i (match_w[k]),
      .entry_o (entry_w[k]),
      .match_o (match_w[k+1])
    );
  end

  assign match_o = match_w[TLB_ENTRIES];

endmodule
`default_nettype wire

// ===== rtl/tlb_page_table_translator_unit.sv =====
// Top level: TLB page-table translator with demand frame assignment.
//
//  channel  | dir | modport | payload
//  req_i    | in  | sink    | virtual_address
//  res_o    | out | source  | physical_address, frame_number, page_number,
//           |     |         | tlb_hit, page_fault, no_free_frame
//
// Each request is handled in order: accept plus page-table RAM read, then the
// TLB chain match and the decision, which writes the result register.
// The TLB is a shift FIFO of cells; a refill shifts the row by one cell.
// Reset clears TLB valid bits, page-present flags and the free-frame counter.
// A waiting result does not block acceptance; the decision cycle stalls until
// the result register is free.
`default_nettype none
module tlb_page_table_translator_unit #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpt_va_if.sink     req_i,
  tpt_res_if.source  res_o
);

  typedef enum logic {ST_IDLE, ST_LOOK} state_e;

  state_e                          state_q;
  logic [tpt_pkg::VA_W-1:0]        va_q;
  logic                            out_valid_q;
  logic [tpt_pkg::VA_W-1:0]        pa_q;
  logic [tpt_pkg::FRAME_W-1:0]     frame_q;
  logic [tpt_pkg::PAGE_W-1:0]      page_q;
  logic                            hit_q;
  logic                            fault_q;
  logic                            full_q;
  logic [tpt_pkg::PAGE_COUNT-1:0]  present_q;
  logic [tpt_pkg::NFF_W-1:0]       nff_q;

  logic                            accept;
  logic                            done;
  logic [tpt_pkg::PAGE_W-1:0]      page;
  logic [tpt_pkg::OFFSET_W-1:0]    offset;
  logic [tpt_pkg::FRAME_W-1:0]     ram_rdata;
  tpt_pkg::tlb_match_t             match;
  tpt_pkg::tlb_entry_t             new_entry;
  logic                            refill;
  logic                            assign_frame;
  logic                            full;
  logic                            fault;
  logic [tpt_pkg::FRAME_W-1:0]     frame;

  assign accept      = req_i.valid && (state_q == ST_IDLE);
  assign req_i.ready = (state_q == ST_IDLE);
  assign done        = (state_q == ST_LOOK) && (!out_valid_q || res_o.ready);

  assign page   = va_q[tpt_pkg::VA_W-1 -: tpt_pkg::PAGE_W];
  assign offset = va_q[tpt_pkg::OFFSET_W-1:0];

  tpt_ram #(
    .WIDTH (tpt_pkg::FRAME_W),
    .DEPTH (tpt_pkg::PAGE_COUNT)
  ) u_page_map (
    .clk_i   (clk_i),
    .we_i    (assign_frame),
    .waddr_i (page),
    .wdata_i (nff_q[tpt_pkg::FRAME_W-1:0]),
    .re_i    (accept),
    .raddr_i (req_i.virtual_address[tpt_pkg::VA_W-1 -: tpt_pkg::PAGE_W]),
    .rdata_o (ram_rdata)
  );

  tpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .refill_i    (refill),
    .new_entry_i (new_entry),
    .page_i      (page),
    .match_o     (match)
  );

  always_comb begin
    full         = 1'b0;
    fault        = 1'b0;
    refill       = 1'b0;
    assign_frame = 1'b0;
    frame        = '0;
    priority if (match.hit) begin
      frame = match.frame;
    end else if (present_q[page]) begin
      frame  = ram_rdata;
      refill = done;
    end else if (nff_q >= tpt_pkg::NFF_W'(tpt_pkg::FRAME_TOTAL)) begin
      full = 1'b1;
    end else begin
      frame        = nff_q[tpt_pkg::FRAME_W-1:0];
      fault        = 1'b1;
      refill       = done;
      assign_frame = done;
    end
  end

  assign new_entry.valid = 1'b1;
  assign new_entry.tag   = page;
  assign new_entry.frame = frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      nff_q     <= '0;
    end else if (assign_frame) begin
      present_q[page] <= 1'b1;
      nff_q           <= nff_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      va_q        <= '0;
      pa_q        <= '0;
      frame_q     <= '0;
      page_q      <= '0;
      hit_q       <= 1'b0;
      fault_q     <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            va_q    <= req_i.virtual_address;
            state_q <= ST_LOOK;
          end
          if (res_o.ready) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_LOOK: begin
          if (done) begin
            out_valid_q <= 1'b1;
            pa_q        <= full ? '0 : {frame, offset};
            frame_q     <= frame;
            page_q      <= page;
            hit_q       <= match.hit;
            fault_q     <= fault;
            full_q      <= full;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.physical_address = pa_q;
  assign res_o.frame_number     = frame_q;
  assign res_o.page_number      = page_q;
  assign res_o.tlb_hit          = hit_q;
  assign res_o.page_fault       = fault_q;
  assign res_o.no_free_frame    = full_q;

endmodule
`default_nettype wire

// ===== sim/tpt_translation_checker.sv =====
// Watches both channels, predicts each translation and compares results in order.
`timescale 1ns / 100ps
module tpt_translation_checker
  import tpt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpt_va_if           req_i,
  tpt_res_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned hit_count_o,
  output int unsigned refill_count_o,
  output int unsigned fault_count_o,
  output int unsigned full_count_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VA_W-1:0]    phys;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
    logic               hit;
    logic               fault;
    logic               full;
  } translation_t;

  translation_t expected_translations[$];
  translation_t want, got;

  logic [PAGE_W-1:0]  tlb_tag   [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame [TLB_ENTRIES];
  logic               tlb_valid [TLB_ENTRIES];
  int unsigned        fill_ptr;
  logic               page_present [PAGE_COUNT];
  logic [FRAME_W-1:0] frame_map    [PAGE_COUNT];
  logic [NFF_W-1:0]   free_frame;

  initial begin
    fail_count_o   = 0;
    hit_count_o    = 0;
    refill_count_o = 0;
    fault_count_o  = 0;
    full_count_o   = 0;
  end

  assign pending_o = expected_translations.size();

  function automatic void tlb_fill(input logic [PAGE_W-1:0] page,
                                   input logic [FRAME_W-1:0] frame);
    tlb_tag[fill_ptr]   = page;
    tlb_frame[fill_ptr] = frame;
    tlb_valid[fill_ptr] = 1'b1;
    fill_ptr = (fill_ptr + 1) % TLB_ENTRIES;
  endfunction

  // Updates the translation state and returns the result the block owes.
  function automatic translation_t translate_address(input logic [VA_W-1:0] va);
    translation_t       t;
    logic [PAGE_W-1:0]  page;
    logic [VA_W-1:0]    offset;
    logic [FRAME_W-1:0] frame;
    bit                 found;
    int                 i;
    page   = PAGE_W'((int'(va) / PAGE_BYTES) % PAGE_COUNT);
    offset = VA_W'(int'(va) % PAGE_BYTES);
    frame  = '0;
    found  = 1'b0;
    t      = '0;
    for (i = 0; i < TLB_ENTRIES; i++) begin
      if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
        found = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (found) begin
      t.hit = 1'b1;
      hit_count_o++;
    end else if (page_present[page]) begin
      frame = frame_map[page];
      tlb_fill(page, frame);
      refill_count_o++;
    end else if (free_frame >= FRAME_TOTAL) begin
      t.full = 1'b1;
      full_count_o++;
    end else begin
      frame              = free_frame[FRAME_W-1:0];
      free_frame         = free_frame + 1'b1;
      frame_map[page]    = frame;
      page_present[page] = 1'b1;
      t.fault            = 1'b1;
      tlb_fill(page, frame);
      fault_count_o++;
    end
    t.page  = page;
    t.frame = frame;
    t.phys  = t.full ? '0 : VA_W'(int'(frame) * PAGE_BYTES + int'(offset));
    return t;
  endfunction

  task automatic note_failure(input string what);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) begin
      $display("%0t mismatch: %s", $realtime, what);
      $display("  expected pa=%h frame=%h page=%h hit=%b fault=%b full=%b",
               want.phys, want.frame, want.page, want.hit, want.fault, want.full);
      $display("  actual   pa=%h frame=%h page=%h hit=%b fault=%b full=%b",
               got.phys, got.frame, got.page, got.hit, got.fault, got.full);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_translations.delete();
      foreach (tlb_valid[i]) begin
        tlb_valid[i] = 1'b0;
        tlb_tag[i]   = '0;
        tlb_frame[i] = '0;
      end
      foreach (page_present[i]) begin
        page_present[i] = 1'b0;
        frame_map[i]    = '0;
      end
      fill_ptr   = 0;
      free_frame = '0;
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.physical_address, res_i.frame_number, res_i.page_number,
                res_i.tlb_hit, res_i.page_fault, res_i.no_free_frame};
        if (expected_translations.size() == 0) begin
          want = '0;
          note_failure("result with no request outstanding");
        end else begin
          want = expected_translations.pop_front();
          if (got !== want) note_failure("translation differs");
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_translations.push_back(translate_address(req_i.virtual_address));
      end
    end
  end

endmodule

// ===== sim/tb_tlb_page_table_translator_unit.sv =====
// Testbench top: clock, reset, address requests, result back-pressure and verdict.
`timescale 1ns / 100ps
module tb_tlb_page_table_translator_unit;
  import tpt_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 450;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RECENT_DEPTH    = 24;

  logic clk_i = 1'b0;
  logic rst_ni;

  tpt_va_if  req ();
  tpt_res_if res ();

  int unsigned fail_count, pending, hits, refills, faults, fulls;
  int unsigned cycle_count = 0;
  int unsigned ready_run = 0;
  int unsigned burst_left = 0;
  int unsigned sent = 0;

  logic [PAGE_W-1:0] used_pages[$];
  logic [PAGE_W-1:0] recent_pages[$];
  bit                page_seen[PAGE_COUNT];

  tlb_page_table_translator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  tpt_translation_checker u_translation_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .res_i          (res),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .hit_count_o    (hits),
    .refill_count_o (refills),
    .fault_count_o  (faults),
    .full_count_o   (fulls)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // result back-pressure: long open stretches, short stalls, short open spells
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          res.ready <= 1'b1;
          ready_run <= $urandom_range(20, 60);
        end
        2, 3, 4, 5: begin
          res.ready <= 1'b0;
          ready_run <= $urandom_range(1, 6);
        end
        default: begin
          res.ready <= 1'b1;
          ready_run <= $urandom_range(1, 8);
        end
      endcase
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // sender bursts: a gap, possibly empty, between bursts, none within one
  task automatic sender_gap();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_request(input logic [VA_W-1:0] va);
    logic [PAGE_W-1:0] page;
    page = va[VA_W-1 -: PAGE_W];
    req.valid           <= 1'b1;
    req.virtual_address <= va;
    do @(posedge clk_i); while (!req.ready);
    sent++;
    if (!page_seen[page]) begin
      page_seen[page] = 1'b1;
      used_pages.push_back(page);
    end
    recent_pages.push_back(page);
    if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
    sender_gap();
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // most often a page touched lately (likely a TLB hit), else an older one (refill) or any page
  function automatic logic [VA_W-1:0] pick_address();
    int unsigned       r;
    logic [PAGE_W-1:0] page;
    r = $urandom_range(0, 99);
    if (r < 45 && recent_pages.size() != 0)
      page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    else if (r < 70 && used_pages.size() != 0)
      page = used_pages[$urandom_range(0, used_pages.size() - 1)];
    else
      page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
    return {page, OFFSET_W'($urandom_range(0, PAGE_BYTES - 1))};
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    req.valid           = 1'b0;
    req.virtual_address = '0;
    res.ready           = 1'b0;
    rst_ni              = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, repeat hits, then a full FIFO wrap that evicts the first pages
    send_request(16'h0000);
    send_request(16'h00FF);
    send_request(16'hFFFF);
    send_request(16'hFF00);
    send_request(16'hAA55);
    send_request(16'h55AA);
    for (int p = 16; p < 32; p++)
      send_request({PAGE_W'(p), OFFSET_W'($urandom_range(0, PAGE_BYTES - 1))});
    // page 0 now evicted: page-table refill, then a hit
    send_request(16'h0012);
    send_request(16'h0034);

    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      send_request(pick_address());
      if (n % 120 == 119) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("%0d requests: %0d TLB hits, %0d page-table refills, %0d page faults, %0d no-frame",
             sent, hits, refills, faults, fulls);
    $display("%0d distinct pages touched, FIFO wrapped with back-pressure on both sides",
             used_pages.size());
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
